// ===== hdl/pma_pkg.sv =====
package pma_pkg;

    localparam int MAX_KERNEL = 8;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int KW  = $clog2(MAX_KERNEL);        // kernel row index bits
    localparam int CW  = $clog2(MAX_WIDTH);         // column index bits
    localparam int RW  = $clog2(MAX_HEIGHT);        // row index bits
    localparam int LS_DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int LSAW = $clog2(LS_DEPTH);
    localparam int NW  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);   // window count bits
    localparam int SW  = 16 + NW;                   // sum width

    localparam logic [2:0] REG_KERNEL = 3'd0;
    localparam logic [2:0] REG_STRIDE = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_MODE   = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic            clear;     // start a new window
        logic            rd_en;     // read store entry
        logic [LSAW-1:0] rd_addr;
        logic            acc_en;    // accumulate registered read data
        logic            div_start;
        logic            load_out;
    } pma_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_busy;
    } pma_sts_t;

endpackage

// ===== hdl/pma_stream_if.sv =====
interface pma_stream_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/pma_ram.sv =====
module pma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/pma_datapath.sv =====
// max/sum accumulator plus restoring signed divider (one quotient bit a cycle)
module pma_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pma_pkg::pma_cmd_t       cmd,
    output pma_pkg::pma_sts_t       sts,
    input  logic                    we,
    input  logic [pma_pkg::LSAW-1:0] waddr,
    input  logic [15:0]             wdata,
    input  logic                    mode,
    output logic [15:0]             result
);
    localparam int SW = pma_pkg::SW;
    localparam int NW = pma_pkg::NW;

    logic [15:0] rdata;
    logic signed [15:0] max_reg;
    logic signed [SW-1:0] sum_reg;
    logic [NW-1:0] cnt_reg;
    logic [SW-1:0] rem_reg, quo_reg;
    logic [$clog2(SW+1)-1:0] bit_reg;
    logic neg_reg, busy_reg;
    logic [SW:0] trial;
    logic [SW-1:0] rem_shift;
    logic [SW-1:0] mag;

    pma_ram #(.WIDTH(16), .DEPTH(pma_pkg::LS_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(rdata)
    );

    assign mag = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign rem_shift = {rem_reg[SW-2:0], quo_reg[SW-1]};
    assign trial = {1'b0, rem_shift} - {{(SW+1-NW){1'b0}}, cnt_reg};
    assign sts.div_busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= ($clog2(SW+1))'(SW);
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg - 1'b1;
                if (bit_reg == ($clog2(SW+1))'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            max_reg <= 16'sh8000;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            if ($signed(rdata) > max_reg)
            begin
                max_reg <= $signed(rdata);
            end
            sum_reg <= sum_reg + SW'($signed(rdata));
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= mag;
            neg_reg <= sum_reg[SW-1];
        end
        else if (busy_reg)
        begin
            if (!trial[SW])
            begin
                rem_reg <= trial[SW-1:0];
                quo_reg <= {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[SW-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
        begin
            if (mode)
            begin
                result <= neg_reg ? 16'(-quo_reg) : quo_reg[15:0];
            end
            else
            begin
                result <= max_reg;
            end
        end
    end
endmodule

// ===== hdl/pma_ctrl.sv =====
// position counters, window sweep and output handshake
module pma_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [8:0]               cfg_data,
    pma_stream_if.sink               in_ch,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic                     out_done,
    output logic                     mode,
    output pma_pkg::pma_cmd_t        cmd,
    input  pma_pkg::pma_sts_t        sts,
    output logic                     we,
    output logic [pma_pkg::LSAW-1:0] waddr
);
    localparam int KW = pma_pkg::KW;
    localparam int CW = pma_pkg::CW;
    localparam int RW = pma_pkg::RW;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_LAST, S_START, S_DIV, S_LOAD, S_OUT
    } state_t;

    state_t state_reg;
    logic [3:0] k_reg, s_reg;
    logic [8:0] h_reg, w_reg;
    logic [RW-1:0] row_reg, orow_reg;
    logic [CW-1:0] col_reg, ocol_reg;
    logic [RW-1:0] hs_reg, hcur_reg;
    logic [CW-1:0] ws_reg, wcur_reg;
    logic [CW:0] we_end_reg;
    logic [RW:0] he_end_reg;
    logic done_reg, valid_reg, mode_reg;

    // effective settings
    logic [4:0] k_e, s_e;
    logic [RW:0] hn;
    logic [CW:0] wn;
    logic rc, cc, lr, lc, acc;
    logic [RW+4:0] hs_w;
    logic [CW+4:0] ws_w;
    logic [RW+5:0] hek;
    logic [CW+5:0] wek;

    always_comb
    begin
        k_e = (k_reg == 4'd0) ? 5'd1 : (k_reg > 4'(pma_pkg::MAX_KERNEL)) ?
              5'(pma_pkg::MAX_KERNEL) : {1'b0, k_reg};
        s_e = (s_reg == 4'd0) ? 5'd1 : ({1'b0, s_reg} > k_e) ? k_e : {1'b0, s_reg};
        hn  = (h_reg == 9'd0) ? (RW+1)'(1) : (h_reg > 9'(pma_pkg::MAX_HEIGHT)) ?
              (RW+1)'(pma_pkg::MAX_HEIGHT) : (RW+1)'(h_reg);
        wn  = (w_reg == 9'd0) ? (CW+1)'(1) : (w_reg > 9'(pma_pkg::MAX_WIDTH)) ?
              (CW+1)'(pma_pkg::MAX_WIDTH) : (CW+1)'(w_reg);
        lr  = ({1'b0, row_reg} + 1'b1 == hn);
        lc  = ({1'b0, col_reg} + 1'b1 == wn);
        // window closes where pos+1 == n, or pos+1 >= k and (pos+1-k) lands on a stride
        // next window start = out*s; closing means pos+1 == start+k (or last)
        hs_w = orow_reg * s_e;
        ws_w = ocol_reg * s_e;
        hek  = (RW+6)'(hs_w) + (RW+6)'(k_e);
        wek  = (CW+6)'(ws_w) + (CW+6)'(k_e);
        rc   = lr || ((RW+6)'(row_reg) + 1'b1 == hek);
        cc   = lc || ((CW+6)'(col_reg) + 1'b1 == wek);
        acc  = in_ch.valid && in_ch.ready;
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign we    = acc;
    assign waddr = {row_reg[KW-1:0], col_reg};
    assign out_valid = valid_reg;
    assign out_done  = done_reg;
    assign mode      = mode_reg;

    always_comb
    begin
        cmd = '0;
        cmd.rd_addr = {hcur_reg[KW-1:0], wcur_reg};
        case (state_reg)
            S_IDLE:
            begin
                cmd.clear = 1'b1;
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                cmd.acc_en = (hcur_reg != hs_reg) || (wcur_reg != ws_reg);
            end
            S_LAST:
            begin
                cmd.acc_en = 1'b1;
            end
            S_START:
            begin
                // sum is complete here
                cmd.div_start = mode_reg;
            end
            S_DIV:
            begin
                cmd.load_out = !sts.div_busy;
            end
            S_LOAD:
            begin
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg <= 4'd1; s_reg <= 4'd1; h_reg <= 9'd1; w_reg <= 9'd1; mode_reg <= 1'b0;
            row_reg <= '0; col_reg <= '0; orow_reg <= '0; ocol_reg <= '0;
            valid_reg <= 1'b0; done_reg <= 1'b0;
            hs_reg <= '0; ws_reg <= '0; hcur_reg <= '0; wcur_reg <= '0;
            he_end_reg <= '0; we_end_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pma_pkg::REG_KERNEL: k_reg <= cfg_data[3:0];
                pma_pkg::REG_STRIDE: s_reg <= cfg_data[3:0];
                pma_pkg::REG_HEIGHT: h_reg <= cfg_data;
                pma_pkg::REG_WIDTH:  w_reg <= cfg_data;
                pma_pkg::REG_MODE:   mode_reg <= cfg_data[0];
                default: ;
            endcase
            if (cfg_index <= pma_pkg::REG_MODE)
            begin
                row_reg <= '0; col_reg <= '0; orow_reg <= '0; ocol_reg <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        if (rc && cc)
                        begin
                            hs_reg   <= RW'(hs_w);
                            ws_reg   <= CW'(ws_w);
                            hcur_reg <= RW'(hs_w);
                            wcur_reg <= CW'(ws_w);
                            he_end_reg <= {1'b0, row_reg} + 1'b1;
                            we_end_reg <= {1'b0, col_reg} + 1'b1;
                            done_reg <= lr && lc;
                            if (lc)
                            begin
                                ocol_reg <= '0;
                                orow_reg <= lr ? '0 : orow_reg + 1'b1;
                            end
                            else
                            begin
                                ocol_reg <= ocol_reg + 1'b1;
                            end
                            state_reg <= S_SCAN;
                        end
                        if (lc)
                        begin
                            col_reg <= '0;
                            row_reg <= lr ? '0 : row_reg + 1'b1;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                S_SCAN:
                begin
                    if ({1'b0, wcur_reg} + 1'b1 == we_end_reg)
                    begin
                        wcur_reg <= ws_reg;
                        if ({1'b0, hcur_reg} + 1'b1 == he_end_reg)
                        begin
                            state_reg <= S_LAST;
                        end
                        else
                        begin
                            hcur_reg <= hcur_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        wcur_reg <= wcur_reg + 1'b1;
                    end
                end
                S_LAST:
                begin
                    state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!sts.div_busy)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== hdl/pool2d_max_average_top.sv =====
// 2-D max / average pooling, ceil mode, over signed Q8.8 samples.
// Channels: sample_in (sink) takes one 16-bit sample per beat in raster
// order, plane after plane; result_out (source) gives {plane_done,
// pooled_value} per beat, bit 16 = plane_done, bits 15:0 = pooled_value.
// Configuration: cfg_we/cfg_index/cfg_data writes kernel, stride,
// in_height, in_width, mode (indexes 0..4); a write to these restarts the plane.
// Flow: a sample that closes no window leaves the controller idle and ready
// for another sample. A closing sample scans the clipped window from the
// line store, one entry a cycle (up to 64) while no configuration write
// comes; a last accumulate step, a start step and, in average mode, a
// restoring divider that runs one quotient bit a cycle (23 bits) follow,
// then the result is loaded into the output register. No sample is taken
// during the scan or the division; the store read port sets the scan.
// Reset: registers return to kernel 1, stride 1, 1x1 plane, max mode;
// counters clear. The line store is not cleared: only entries written in
// the current plane are ever read.
// Stall: the result is held in an output register until taken; no new
// sample is accepted while a result waits.
module pool2d_max_average_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    pma_stream_if.sink   sample_in,
    pma_stream_if.source result_out
);
    pma_pkg::pma_cmd_t cmd;
    pma_pkg::pma_sts_t sts;
    logic                     we;
    logic [pma_pkg::LSAW-1:0] waddr;
    logic                     mode;
    logic                     done;
    logic [15:0]              result;

    pma_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_ch(sample_in),
        .out_ready(result_out.ready), .out_valid(result_out.valid), .out_done(done),
        .mode(mode), .cmd(cmd), .sts(sts), .we(we), .waddr(waddr)
    );

    pma_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .we(we), .waddr(waddr), .wdata(sample_in.data),
        .mode(mode), .result(result)
    );

    assign result_out.data = {done, result};
endmodule

// ===== verif/pma_stream_if.sv =====
`timescale 1ns / 100ps

// ===== verif/pool2d_max_average_top_tb.sv =====
`timescale 1ns / 100ps
module pool2d_max_average_top_tb;

    // Pooled-value predictor and the queue of expected output beats.
    class pool_scoreboard;
        int unsigned kernel, stride, height, width;
        bit          avg_mode;
        logic [15:0] rows [pma_pkg::MAX_KERNEL][pma_pkg::MAX_WIDTH];
        int unsigned row_pos, col_pos, win_row, win_col;
        logic [16:0] pending_beats [$];
        int          errors;

        function void reset_regs();
            kernel = 1; stride = 1; height = 1; width = 1; avg_mode = 0;
            row_pos = 0; col_pos = 0; win_row = 0; win_col = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [8:0] value);
            case (idx)
                pma_pkg::REG_KERNEL: kernel = value[3:0];
                pma_pkg::REG_STRIDE: stride = value[3:0];
                pma_pkg::REG_HEIGHT: height = value;
                pma_pkg::REG_WIDTH:  width = value;
                pma_pkg::REG_MODE:   avg_mode = value[0];
                default: return;
            endcase
            row_pos = 0; col_pos = 0; win_row = 0; win_col = 0;
        endfunction

        function bit window_ends(int unsigned pos, int unsigned n, int unsigned k,
                                 int unsigned s);
            if (pos + 1 == n) return 1;
            if (pos + 1 < k) return 0;
            return ((pos + 1 - k) % s) == 0;
        endfunction

        // Notes one accepted sample; queues a pooled value if a window closes.
        function void note_sample(logic [15:0] smp);
            int unsigned k, s, hn, wn, hs, ws, he, we, n;
            int          mx, sum, v, res;
            bit          last_r, last_c;
            k  = (kernel < 1) ? 1 : (kernel > pma_pkg::MAX_KERNEL) ?
                 pma_pkg::MAX_KERNEL : kernel;
            s  = (stride < 1) ? 1 : (stride > k) ? k : stride;
            hn = (height < 1) ? 1 : (height > pma_pkg::MAX_HEIGHT) ?
                 pma_pkg::MAX_HEIGHT : height;
            wn = (width < 1) ? 1 : (width > pma_pkg::MAX_WIDTH) ?
                 pma_pkg::MAX_WIDTH : width;
            if (row_pos >= hn || col_pos >= wn)
            begin
                row_pos = 0; col_pos = 0; win_row = 0; win_col = 0;
            end
            rows[row_pos % pma_pkg::MAX_KERNEL][col_pos] = smp;
            last_r = (row_pos + 1 == hn);
            last_c = (col_pos + 1 == wn);
            if (window_ends(row_pos, hn, k, s) && window_ends(col_pos, wn, k, s))
            begin
                hs = win_row * s; ws = win_col * s;
                he = (hs + k < hn) ? hs + k : hn;
                we = (ws + k < wn) ? ws + k : wn;
                mx = -32768; sum = 0; n = 0;
                for (int unsigned h = hs; h < he; h++)
                    for (int unsigned w = ws; w < we; w++)
                    begin
                        v = $signed(rows[h % pma_pkg::MAX_KERNEL][w]);
                        if (v > mx) mx = v;
                        sum += v;
                        n++;
                    end
                res = avg_mode ? sum / int'(n) : mx;
                pending_beats.push_back({last_r && last_c, res[15:0]});
                if (last_c)
                begin
                    win_col = 0;
                    win_row = last_r ? 0 : win_row + 1;
                end
                else
                    win_col++;
            end
            col_pos++;
            if (col_pos >= wn)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= hn) row_pos = 0;
            end
        endfunction

        task report(string msg);
            $display("%s", msg);
            errors++;
        endtask

        task check_result(logic [16:0] got);
            logic [16:0] want;
            if (pending_beats.size() == 0)
            begin
                report($sformatf("unexpected result beat %h", got));
                return;
            end
            want = pending_beats.pop_front();
            if (got[15:0] !== want[15:0])
                report($sformatf("pooled_value got %h want %h", got[15:0], want[15:0]));
            if (got[16] !== want[16])
                report($sformatf("plane_done got %b want %b", got[16], want[16]));
        endtask
    endclass

    localparam int STALL_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [8:0] cfg_data;
    bit         calm;           // no idling on either side in the final stretch
    int         idle_cycles;
    pool_scoreboard sb;

    pma_stream_if #(16) sample_in ();
    pma_stream_if #(17) result_out ();

    pool2d_max_average_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in.sink),
        .result_out (result_out.source)
    );

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // Sample and result beats are observed at the edge, before new drives land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_in.valid && sample_in.ready)
                sb.note_sample(sample_in.data);
            if (result_out.valid && result_out.ready)
                sb.check_result(result_out.data);
        end
    end

    // Watchdog: counts cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((sample_in.valid && sample_in.ready) || (result_out.valid && result_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: ready is dropped at random, except in the calm tail.
    initial
    begin
        int gap;
        result_out.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 3);
                result_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_out.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // cfg_we is dropped by the caller once the last write is done.
    task automatic write_reg(logic [2:0] idx, logic [8:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    // Waits for all queued results, then lets a closing scan finish.
    task automatic drain();
        sample_in.valid <= 1'b0;
        while (sb.pending_beats.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic set_shape(int k, int s, int h, int w, bit avg);
        drain();
        write_reg(pma_pkg::REG_KERNEL, 9'(k));
        write_reg(pma_pkg::REG_STRIDE, 9'(s));
        write_reg(pma_pkg::REG_HEIGHT, 9'(h));
        write_reg(pma_pkg::REG_WIDTH, 9'(w));
        write_reg(pma_pkg::REG_MODE, 9'(avg));
        cfg_we <= 1'b0;
    endtask

    // One sample beat; the valid stays high across back-to-back beats.
    task automatic send_sample(logic [15:0] smp);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 3);
            sample_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_in.valid <= 1'b1;
        sample_in.data  <= smp;
        @(posedge clk);
        while (!sample_in.ready) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(-$urandom_range(1, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_plane(int h, int w);
        for (int i = 0; i < h * w; i++) send_sample(rand_sample());
    endtask

    initial
    begin
        int k, s, h, w, sent, n, reps;
        sb = new();
        sb.reset_regs();
        calm = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= pma_pkg::REG_KERNEL;
        cfg_data <= '0;
        sample_in.valid <= 1'b0;
        sample_in.data <= '0;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed: reset shape (1x1 max), extremes of the sample field.
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'hffff);
        // Average over extremes, truncation of a negative sum toward zero.
        set_shape(2, 2, 2, 2, 1);
        send_sample(16'h8000); send_sample(16'h8000);
        send_sample(16'h8000); send_sample(16'h7fff);
        send_sample(16'hffff); send_sample(16'hfffe);
        send_sample(16'h0000); send_sample(16'h0000);
        // Plane smaller than the kernel: whole plane is one clipped window.
        set_shape(8, 3, 2, 3, 0);
        send_sample(16'h8000); send_sample(16'h0001); send_sample(16'h8001);
        send_sample(16'h7fff); send_sample(16'h0000); send_sample(16'hffff);
        // Out-of-range registers: kernel 0, stride above kernel, zero dims, max dims.
        set_shape(0, 0, 0, 0, 0);
        send_sample(16'h1234);
        set_shape(15, 15, 3, 3, 1);
        send_plane(3, 3);
        set_shape(3, 9, 511, 2, 0);
        send_plane(4, 2);
        // Pause until every result has arrived.
        drain();

        // Random shapes, mostly small planes; an occasional wide one.
        sent = 0;
        while (sent < 1750)
        begin
            k = $urandom_range(1, 8);
            s = $urandom_range(1, k);
            if ($urandom_range(0, 15) == 0)
            begin
                h = $urandom_range(1, 2); w = $urandom_range(200, 256);
            end
            else
            begin
                h = $urandom_range(1, 10); w = $urandom_range(1, 12);
            end
            set_shape(k, s, h, w, $urandom_range(0, 1));
            if (sent > 1500) calm = 1;
            // Sometimes a partial plane, cut off by the next register write.
            if ($urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, h * w);
                for (int i = 0; i < n; i++) send_sample(rand_sample());
                sent += n;
            end
            else
            begin
                reps = $urandom_range(1, 3);
                for (int p = 0; p < reps; p++) send_plane(h, w);
                sent += reps * h * w;
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
